// ----- rtl/assert_macros.svh -----
// assertion macros shared by the swing-up law rtl
// no dependencies; included by the files that carry checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PESU_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");
`define PESU_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("%m: check failed");
`else
`define PESU_ASSERT(lbl, clk, rst_n, prop)
`define PESU_ASSERT_RST(lbl, clk, prop)
`endif
`endif

// ----- rtl/pesu_pkg.sv -----
// constants, register codes and table builders for the swing-up law
// no dependencies; used by pesu_div, pesu_ln and the top level
package pesu_pkg;

    localparam int TRIG_TABLE_BITS_DEF = 10;
    localparam int LOG_TABLE_BITS_DEF  = 10;

    typedef enum logic [2:0] {
        CFG_SWING_GAIN      = 3'd0,
        CFG_WALL_GAIN       = 3'd1,
        CFG_TRACK_HALF_LEN  = 3'd2,
        CFG_UPRIGHT_ENERGY  = 3'd3,
        CFG_POSITION_GAIN   = 3'd4,
        CFG_VELOCITY_GAIN   = 3'd5,
        CFG_BALANCE_LIMIT   = 3'd6,
        CFG_FRACTION_BASE   = 3'd7
    } t_cfg_idx;

    localparam logic [23:0] RST_SWING_GAIN     = 24'd153600;
    localparam logic [23:0] RST_WALL_GAIN      = 24'd210432;
    localparam logic [22:0] RST_TRACK_HALF_LEN = 23'd38400;
    localparam logic [31:0] RST_UPRIGHT_ENERGY = 32'd34088196;
    localparam logic [15:0] RST_POSITION_GAIN  = 16'd256;
    localparam logic [15:0] RST_VELOCITY_GAIN  = 16'd384;
    localparam logic [17:0] RST_BALANCE_LIMIT  = 18'd5719;
    localparam logic [15:0] RST_FRACTION_BASE  = 16'd42598;

    localparam logic [29:0] INV_TWO_PI_Q32  = 30'd683565276;
    localparam logic [29:0] LN2_Q30         = 30'd744261118;
    localparam logic [18:0] HALF_INERTIA_Q8 = 19'd342634;
    localparam logic [25:0] MGL_Q8          = 26'd34088196;
    localparam logic [27:0] RAMP_DIV        = 28'd250000000;
    // floor(2^41 / RAMP_DIV), estimate error stays below one
    localparam logic [13:0] RAMP_RECIP      = 14'd8796;

    // track ratio divider: 16 quotient bits, two per stage
    localparam int DIV_STAGES     = 8;
    localparam int DIV_STEP_BITS  = 2;

    localparam logic [63:0] Q30_ONE    = 64'd1 << 30;
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

    // restoring division, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[63:0], a[i]};
            if (r >= {1'b0, b}) begin
                r = r - {1'b0, b};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] cos_div(input int i);
        case (i)
            0:       return 64'd132;
            1:       return 64'd90;
            2:       return 64'd56;
            3:       return 64'd30;
            4:       return 64'd12;
            default: return 64'd2;
        endcase
    endfunction

    // cos(2pi*r/2^tb) in q16 for r in the first quarter
    function automatic logic [63:0] cos_entry(input logic [63:0] r, input int tb);
        logic [63:0] a, a2, t, x;
        a  = (r * TWO_PI_Q30) >> tb;
        a2 = (a * a) >> 30;
        t  = Q30_ONE;
        for (int i = 0; i < 6; i++) begin
            x = udiv64((a2 * t) >> 30, cos_div(i));
            t = (x >= Q30_ONE) ? 64'd0 : Q30_ONE - x;
        end
        return (t + (64'd1 << 13)) >> 14;
    endfunction

    // ln(1 + k/2^lb) in q30
    function automatic logic [63:0] ln_entry(input logic [63:0] k, input int lb);
        logic [63:0] n, z, z2, term, sum;
        n    = 64'd1 << lb;
        z    = udiv64(k << 30, 2 * n + k);
        z2   = (z * z) >> 30;
        term = z;
        sum  = '0;
        for (int i = 0; i < 14; i++) begin
            sum  = sum + udiv64(term, 64'(2 * i + 1));
            term = (term * z2) >> 30;
        end
        return 2 * sum;
    endfunction

endpackage

// ----- rtl/pesu_div.sv -----
// pipelined restoring divider for the cart-to-track ratio
// depends on pesu_pkg; stage enables come from the top level
module pesu_div (
    input  logic                              i_clk,
    input  logic [pesu_pkg::DIV_STAGES-1:0]   i_en,
    input  logic [22:0]                       i_rem,
    input  logic                              i_sat,
    input  logic [22:0]                       i_divisor,
    output logic [15:0]                       o_q
);

    localparam int NS = pesu_pkg::DIV_STAGES;
    localparam int SB = pesu_pkg::DIV_STEP_BITS;

    logic [22:0] r_rem [0:NS-1];
    logic [15:0] r_q   [0:NS-1];
    logic        r_sat [0:NS-1];
    logic [22:0] n_rem [0:NS-1];
    logic [15:0] n_q   [0:NS-1];
    logic        n_sat [0:NS-1];

    always_comb begin
        logic [22:0] rem;
        logic [15:0] q;
        logic [23:0] t;
        for (int j = 0; j < NS; j++) begin
            rem = (j == 0) ? i_rem : r_rem[(j == 0) ? 0 : j - 1];
            q   = (j == 0) ? 16'd0 : r_q[(j == 0) ? 0 : j - 1];
            n_sat[j] = (j == 0) ? i_sat : r_sat[(j == 0) ? 0 : j - 1];
            for (int s = 0; s < SB; s++) begin
                t = {rem, 1'b0};
                if (t >= {1'b0, i_divisor}) begin
                    rem = 23'(t - {1'b0, i_divisor});
                    q   = {q[14:0], 1'b1};
                end else begin
                    rem = t[22:0];
                    q   = {q[14:0], 1'b0};
                end
            end
            n_rem[j] = rem;
            n_q[j]   = q;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < NS; j++) begin
            if (i_en[j]) begin
                r_rem[j] <= n_rem[j];
                r_q[j]   <= n_q[j];
                r_sat[j] <= n_sat[j];
            end
        end
    end

    // cart at or past the track end clamps the ratio
    assign o_q = r_sat[NS-1] ? 16'hFFFF : r_q[NS-1];

endmodule

// ----- rtl/pesu_ln.sv -----
// three-stage |ln(1 - r)| unit: normalize, table read, combine
// depends on pesu_pkg for the log table builder and ln2
module pesu_ln #(
    parameter int LOG_TABLE_BITS = pesu_pkg::LOG_TABLE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic [2:0]  i_en,
    input  logic [15:0] i_ratio,
    output logic [19:0] o_lnq
);

    localparam int LB   = LOG_TABLE_BITS;
    localparam int LN_N = 1 << LB;

    typedef logic [29:0] t_ln_rom [0:LN_N];

    function automatic t_ln_rom build_ln();
        t_ln_rom rom;
        for (int k = 0; k <= LN_N; k++) begin
            rom[k] = 30'(pesu_pkg::ln_entry(64'(k), LB));
        end
        return rom;
    endfunction

    localparam t_ln_rom LN_ROM = build_ln();

    logic [LB:0]  r_idx;
    logic [4:0]   r_e1;
    logic         r_zero1;
    logic [29:0]  r_lnv;
    logic [4:0]   r_e2;
    logic         r_zero2;
    logic [19:0]  r_lnq;

    logic [16:0]  y;
    logic [3:0]   lead;
    logic [4:0]   n_e;
    logic [31:0]  shifted;
    logic [16:0]  idx_sum;
    logic [34:0]  m;
    logic [34:0]  m_rnd;

    always_comb begin
        y    = 17'h10000 - {1'b0, i_ratio};
        lead = '0;
        for (int i = 0; i < 16; i++) begin
            if (y[i]) lead = 4'(i);
        end
        n_e     = 5'd16 - {1'b0, lead};
        shifted = {16'd0, y[15:0]} << n_e;
        idx_sum = {1'b0, shifted[15:0]} + (17'd1 << (15 - LB));
    end

    always_comb begin
        m     = 35'(r_e2) * 35'(pesu_pkg::LN2_Q30) - 35'(r_lnv);
        m_rnd = (m + (35'd1 << 13)) >> 14;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_idx   <= (LB + 1)'(idx_sum >> (16 - LB));
            r_e1    <= n_e;
            r_zero1 <= (i_ratio == 16'd0);
        end
        if (i_en[1]) begin
            r_lnv   <= LN_ROM[r_idx];
            r_e2    <= r_e1;
            r_zero2 <= r_zero1;
        end
        if (i_en[2]) begin
            r_lnq   <= r_zero2 ? 20'd0 : m_rnd[19:0];
        end
    end

    assign o_lnq = r_lnq;

endmodule

// ----- rtl/pendulum_energy_swing_up_law_core.sv -----
// top level of the energy swing-up law: config registers and 14-stage pipeline
// depends on pesu_pkg, pesu_div, pesu_ln and assert_macros.svh
//
// channel  | handshake                 | beat
// ---------+---------------------------+-----------------------------------------
// sample   | i_valid / o_stall         | position, velocity, angle, rate, time
// command  | o_valid / i_stall         | drive_accel, pumping, can_balance
// config   | i_cfg_valid / o_cfg_ready | index and data of one register
//
// one sample enters per cycle while o_stall is low; the pipe depth is set by the
// divider stages of the track ratio (two quotient bits each) and the log unit
// each stage holds while the stage after it is full and stalled, so bubbles
// close up and a free slot still takes a beat while the output waits
// reset clears all valid bits and loads the register defaults; config is
// always ready, and no clearing pass is needed
`include "assert_macros.svh"

module pendulum_energy_swing_up_law_core #(
    parameter int TRIG_TABLE_BITS = pesu_pkg::TRIG_TABLE_BITS_DEF,
    parameter int LOG_TABLE_BITS  = pesu_pkg::LOG_TABLE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [23:0] i_cart_position,
    input  logic signed [23:0] i_cart_velocity,
    input  logic signed [18:0] i_pendulum_angle,
    input  logic signed [23:0] i_angular_rate,
    input  logic        [24:0] i_swing_elapsed_us,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_drive_accel,
    output logic               o_pumping,
    output logic               o_can_balance,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic        [2:0]  i_cfg_index,
    input  logic        [31:0] i_cfg_data
);

    localparam int NSTG   = 14;
    localparam int TB     = TRIG_TABLE_BITS;
    localparam int TRIG_N = 1 << TB;
    localparam int HALF_N = TRIG_N / 2;
    localparam int QTR_N  = TRIG_N / 4;

    // quarter-wave cosine table, folded by symmetry
    typedef logic [16:0] t_cos_rom [0:QTR_N];

    function automatic t_cos_rom build_cos();
        t_cos_rom rom;
        for (int k = 0; k <= QTR_N; k++) begin
            rom[k] = 17'(pesu_pkg::cos_entry(64'(k), TB));
        end
        return rom;
    endfunction

    localparam t_cos_rom COS_ROM = build_cos();

    // side data riding along the whole pipe
    typedef struct packed {
        logic               bal;
        logic               xneg;
        logic               xnz;
        logic               wneg;
        logic               wnz;
        logic               bnz;
        logic               bneg;
        logic               pump;
        logic signed [34:0] uc;
    } t_tail;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [23:0] r_swing_gain;
    logic [23:0] r_wall_gain;
    logic [22:0] r_track_half_len;
    logic [31:0] r_upright_energy;
    logic [15:0] r_position_gain;
    logic [15:0] r_velocity_gain;
    logic [17:0] r_balance_limit;
    logic [15:0] r_fraction_base;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swing_gain     <= pesu_pkg::RST_SWING_GAIN;
            r_wall_gain      <= pesu_pkg::RST_WALL_GAIN;
            r_track_half_len <= pesu_pkg::RST_TRACK_HALF_LEN;
            r_upright_energy <= pesu_pkg::RST_UPRIGHT_ENERGY;
            r_position_gain  <= pesu_pkg::RST_POSITION_GAIN;
            r_velocity_gain  <= pesu_pkg::RST_VELOCITY_GAIN;
            r_balance_limit  <= pesu_pkg::RST_BALANCE_LIMIT;
            r_fraction_base  <= pesu_pkg::RST_FRACTION_BASE;
        end else if (i_cfg_valid) begin
            case (pesu_pkg::t_cfg_idx'(i_cfg_index))
                pesu_pkg::CFG_SWING_GAIN:     r_swing_gain     <= i_cfg_data[23:0];
                pesu_pkg::CFG_WALL_GAIN:      r_wall_gain      <= i_cfg_data[23:0];
                pesu_pkg::CFG_TRACK_HALF_LEN: r_track_half_len <= i_cfg_data[22:0];
                pesu_pkg::CFG_UPRIGHT_ENERGY: r_upright_energy <= i_cfg_data;
                pesu_pkg::CFG_POSITION_GAIN:  r_position_gain  <= i_cfg_data[15:0];
                pesu_pkg::CFG_VELOCITY_GAIN:  r_velocity_gain  <= i_cfg_data[15:0];
                pesu_pkg::CFG_BALANCE_LIMIT:  r_balance_limit  <= i_cfg_data[17:0];
                pesu_pkg::CFG_FRACTION_BASE:  r_fraction_base  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage valids and enables: a stage moves when empty or drained
    // ------------------------------------------------------------------
    logic [NSTG:1]   r_v;
    logic [NSTG+1:1] en;

    always_comb begin
        en[NSTG+1] = !i_stall;
        for (int k = NSTG; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 1; k <= NSTG; k++) begin
                if (en[k]) r_v[k] <= (k == 1) ? i_valid : r_v[(k == 1) ? 1 : k - 1];
            end
        end
    end

    assign o_stall = !en[1];
    assign o_valid = r_v[NSTG];

    // ------------------------------------------------------------------
    // stage 1: magnitudes, angle scaling, rate square, ramp estimate
    // ------------------------------------------------------------------
    logic [18:0] ath;
    logic [23:0] aw;
    logic [23:0] ax;

    assign ath = i_pendulum_angle[18] ? 19'(-i_pendulum_angle) : 19'(i_pendulum_angle);
    assign aw  = i_angular_rate[23]   ? 24'(-i_angular_rate)   : 24'(i_angular_rate);
    assign ax  = i_cart_position[23]  ? 24'(-i_cart_position)  : 24'(i_cart_position);

    logic [48:0]        r1_prod;
    logic [47:0]        r1_aw2;
    logic signed [23:0] r1_x;
    logic signed [23:0] r1_v;
    logic [24:0]        r1_us;
    logic [38:0]        r1_usr;
    logic [22:0]        r1_rem;
    logic               r1_sat;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_prod <= 49'(ath) * 49'(pesu_pkg::INV_TWO_PI_Q32);
            r1_aw2  <= 48'(aw) * 48'(aw);
            r1_x    <= i_cart_position;
            r1_v    <= i_cart_velocity;
            r1_us   <= i_swing_elapsed_us;
            r1_usr  <= 39'(i_swing_elapsed_us) * 39'(pesu_pkg::RAMP_RECIP);
            r1_rem  <= ax[22:0];
            // at or past the track end, and zero track length
            r1_sat  <= (ax >= {1'b0, r_track_half_len});
        end
    end

    // ------------------------------------------------------------------
    // stage 2: cosine lookup, kinetic term scaling, centering products
    // ------------------------------------------------------------------
    logic [49:0]  idx_sum;
    logic [TB:0]  kf;
    logic         cneg_n;

    always_comb begin
        idx_sum = {1'b0, r1_prod} + (50'd1 << (47 - TB));
        kf      = {1'b0, idx_sum[48-TB +: TB]};
        cneg_n  = 1'b0;
        if (kf > (TB + 1)'(HALF_N)) kf = (TB + 1)'(TRIG_N) - kf;
        if (kf > (TB + 1)'(QTR_N)) begin
            cneg_n = 1'b1;
            kf     = (TB + 1)'(HALF_N) - kf;
        end
    end

    logic [16:0]        r2_cmag;
    logic               r2_cneg;
    logic [30:0]        r2_ke1;
    logic signed [40:0] r2_px;
    logic signed [40:0] r2_pv;
    logic [13:0]        r2_q0;
    logic [24:0]        r2_us;

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_cmag <= COS_ROM[kf[TB-2:0]];
            r2_cneg <= cneg_n;
            r2_ke1  <= r1_aw2[46:16];
            r2_px   <= $signed({1'b0, r_position_gain}) * r1_x;
            r2_pv   <= $signed({1'b0, r_velocity_gain}) * r1_v;
            r2_q0   <= r1_usr[38:25];
            r2_us   <= r1_us;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: kinetic energy, ramp check product, centering sum
    // ------------------------------------------------------------------
    logic [33:0]        r3_ke;
    logic [41:0]        r3_qd;
    logic [13:0]        r3_q0;
    logic [24:0]        r3_us;
    logic signed [41:0] r3_s;
    logic [16:0]        r3_cmag;
    logic               r3_cneg;
    logic [49:0]        ke_prod;

    assign ke_prod = 50'(r2_ke1) * 50'(pesu_pkg::HALF_INERTIA_Q8);

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r3_ke   <= ke_prod[49:16];
            r3_qd   <= 42'(r2_q0) * 42'(pesu_pkg::RAMP_DIV);
            r3_q0   <= r2_q0;
            r3_us   <= r2_us;
            r3_s    <= 42'(r2_px) + 42'(r2_pv);
            r3_cmag <= r2_cmag;
            r3_cneg <= r2_cneg;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: potential energy, corrected ramp, centering command
    // ------------------------------------------------------------------
    logic [33:0] r4_ke;
    logic [26:0] r4_pe;
    logic        r4_cneg;
    logic [13:0] r4_q;
    logic [42:0] pe_prod;
    logic [41:0] ramp_rem;

    assign pe_prod  = 43'(pesu_pkg::MGL_Q8) * 43'(r3_cmag);
    assign ramp_rem = {1'b0, r3_us, 16'd0} - r3_qd;

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r4_ke   <= r3_ke;
            r4_pe   <= pe_prod[42:16];
            r4_cneg <= r3_cneg;
            r4_q    <= r3_q0 + 14'(ramp_rem >= 42'(pesu_pkg::RAMP_DIV));
        end
    end

    // ------------------------------------------------------------------
    // stages 5 to 7: energy, threshold, branch decision
    // ------------------------------------------------------------------
    logic signed [35:0] r5_e;
    logic [16:0]        r5_aq;
    logic signed [35:0] r6_e;
    logic [32:0]        r6_thr;
    logic [48:0]        thr_prod;

    assign thr_prod = 49'(r_upright_energy) * 49'(r5_aq);

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r5_e  <= r4_cneg ? $signed({2'b0, r4_ke}) - $signed({9'b0, r4_pe})
                             : $signed({2'b0, r4_ke}) + $signed({9'b0, r4_pe});
            r5_aq <= 17'(r_fraction_base) + 17'(r4_q);
        end
        if (en[6]) begin
            r6_e   <= r5_e;
            r6_thr <= thr_prod[48:16];
        end
    end

    // ------------------------------------------------------------------
    // side data through stages 1 to 13
    // ------------------------------------------------------------------
    t_tail r_tail [1:NSTG-1];
    t_tail n_tail [1:NSTG-1];

    logic signed [42:0] neg_s;
    assign neg_s = -{r3_s[41], r3_s};

    always_comb begin
        n_tail[1].bal  = (ath <= {1'b0, r_balance_limit});
        n_tail[1].xneg = i_cart_position[23];
        n_tail[1].xnz  = (i_cart_position != 24'sd0);
        n_tail[1].wneg = i_angular_rate[23];
        n_tail[1].wnz  = (i_angular_rate != 24'sd0);
        n_tail[1].bnz  = 1'b0;
        n_tail[1].bneg = 1'b0;
        n_tail[1].pump = 1'b0;
        n_tail[1].uc   = '0;
        for (int k = 2; k <= NSTG - 1; k++) begin
            n_tail[k] = r_tail[k-1];
            if (k == 3) begin
                // pumping term is -sign(w)*sign(cos)*gain, zero when either is zero
                n_tail[k].bnz  = r_tail[k-1].wnz && (r2_cmag != 17'd0);
                n_tail[k].bneg = !(r_tail[k-1].wneg ^ r2_cneg);
            end
            if (k == 4) n_tail[k].uc = 35'(neg_s >>> 8);
            if (k == 7) n_tail[k].pump = (r6_e <= $signed({3'b0, r6_thr}));
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 1; k <= NSTG - 1; k++) begin
            if (en[k]) r_tail[k] <= n_tail[k];
        end
    end

    // ------------------------------------------------------------------
    // stages 2 to 12: track ratio and wall log
    // ------------------------------------------------------------------
    logic [15:0] div_q;
    logic [19:0] lnq;

    pesu_div u_div (
        .i_clk     (i_clk),
        .i_en      (en[pesu_pkg::DIV_STAGES+1:2]),
        .i_rem     (r1_rem),
        .i_sat     (r1_sat),
        .i_divisor (r_track_half_len),
        .o_q       (div_q)
    );

    pesu_ln #(
        .LOG_TABLE_BITS (LOG_TABLE_BITS)
    ) u_ln (
        .i_clk   (i_clk),
        .i_en    (en[12:10]),
        .i_ratio (div_q),
        .o_lnq   (lnq)
    );

    // ------------------------------------------------------------------
    // stage 13: wall term; stage 14: branch select and saturation
    // ------------------------------------------------------------------
    logic [27:0]        r13_wall;
    logic [43:0]        wall_prod;
    logic signed [29:0] bang;
    logic signed [29:0] wall_term;
    logic signed [35:0] u_sel;
    logic signed [31:0] u_sat;

    assign wall_prod = 44'(r_wall_gain) * 44'(lnq);

    always_comb begin
        bang      = '0;
        wall_term = '0;
        if (r_tail[13].bnz) begin
            bang = r_tail[13].bneg ? -$signed({6'b0, r_swing_gain})
                                   :  $signed({6'b0, r_swing_gain});
        end
        // a cart left of center is pushed right, and the other way
        if (r_tail[13].xnz) begin
            wall_term = r_tail[13].xneg ?  $signed({2'b0, r13_wall})
                                        : -$signed({2'b0, r13_wall});
        end
        u_sel = r_tail[13].pump ? 36'(bang + wall_term) : 36'(r_tail[13].uc);
        if (u_sel > 36'sh0_7FFF_FFFF) begin
            u_sat = 32'sh7FFF_FFFF;
        end else if (u_sel < -36'sh0_8000_0000) begin
            u_sat = -32'sh8000_0000;
        end else begin
            u_sat = u_sel[31:0];
        end
    end

    logic signed [31:0] r14_accel;
    logic               r14_pump;
    logic               r14_bal;

    always_ff @(posedge i_clk) begin
        if (en[13]) r13_wall <= wall_prod[43:16];
        if (en[14]) begin
            r14_accel <= u_sat;
            r14_pump  <= r_tail[13].pump;
            r14_bal   <= r_tail[13].bal;
        end
    end

    assign o_drive_accel = r14_accel;
    assign o_pumping     = r14_pump;
    assign o_can_balance = r14_bal;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `PESU_ASSERT_RST(a_reset_empties, i_clk, !i_rst_n |=> !o_valid)
    `PESU_ASSERT(a_free_out_free_in, i_clk, i_rst_n, !i_stall |-> !o_stall)
    `PESU_ASSERT(a_held_stage_keeps, i_clk, i_rst_n, (r_v[1] && !en[1]) |=> r_v[1])
    `PESU_ASSERT(a_pump_bounded, i_clk, i_rst_n, (o_valid && o_pumping) |-> ((o_drive_accel < 32'sd536870912) && (o_drive_accel > -32'sd536870912)))

endmodule

// ----- tb/sv/tb_pendulum_energy_swing_up_law_core.sv -----
// self-checking testbench for the energy swing-up law core
// depends on pesu_pkg and pendulum_energy_swing_up_law_core
`timescale 1ns / 100ps

module tb_pendulum_energy_swing_up_law_core;

    localparam int TRIG_BITS = 10;
    localparam int LOG_BITS  = 10;
    localparam int LATENCY   = 14;
    localparam int PHASES    = 8;
    localparam int PER_PHASE = 200;

    localparam longint unsigned INV_2PI_Q32 = 64'd683565276;
    localparam longint unsigned LN2_Q30_C   = 64'd744261118;
    localparam longint unsigned HALF_INER   = 64'd342634;
    localparam longint unsigned MGL         = 64'd34088196;
    localparam longint unsigned RAMP_DEN    = 64'd250000000;
    localparam longint unsigned ONE_Q30     = 64'd1 << 30;
    localparam longint unsigned TWOPI_Q30   = 64'd6746518852;
    // angle of a quarter turn in q16, lands on the zero-cosine table entry
    localparam int QUARTER_TURN = 102944;

    typedef struct {
        logic signed [23:0] pos;
        logic signed [23:0] vel;
        logic signed [18:0] ang;
        logic signed [23:0] rate;
        logic        [24:0] us;
    } t_sample;

    typedef struct {
        logic signed [31:0] accel;
        logic               pump;
        logic               bal;
    } t_command;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [23:0] i_cart_position = '0;
    logic signed [23:0] i_cart_velocity = '0;
    logic signed [18:0] i_pendulum_angle = '0;
    logic signed [23:0] i_angular_rate = '0;
    logic        [24:0] i_swing_elapsed_us = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [31:0] o_drive_accel;
    logic               o_pumping;
    logic               o_can_balance;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic        [2:0]  i_cfg_index = '0;
    logic        [31:0] i_cfg_data = '0;

    pendulum_energy_swing_up_law_core i_dut (.*);

    always #4 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // predictor state: register shadow and the two lookup tables
    // ---------------------------------------------------------------
    longint unsigned gain_regs[8];
    longint signed   cos_tab[1 << TRIG_BITS];
    longint unsigned lnq30_tab[(1 << LOG_BITS) + 1];

    function automatic int reg_bits(int idx);
        case (idx)
            pesu_pkg::CFG_SWING_GAIN, pesu_pkg::CFG_WALL_GAIN: return 24;
            pesu_pkg::CFG_TRACK_HALF_LEN:                      return 23;
            pesu_pkg::CFG_UPRIGHT_ENERGY:                      return 32;
            pesu_pkg::CFG_BALANCE_LIMIT:                       return 18;
            default:                                           return 16;
        endcase
    endfunction

    task automatic load_defaults();
        gain_regs[pesu_pkg::CFG_SWING_GAIN]     = pesu_pkg::RST_SWING_GAIN;
        gain_regs[pesu_pkg::CFG_WALL_GAIN]      = pesu_pkg::RST_WALL_GAIN;
        gain_regs[pesu_pkg::CFG_TRACK_HALF_LEN] = pesu_pkg::RST_TRACK_HALF_LEN;
        gain_regs[pesu_pkg::CFG_UPRIGHT_ENERGY] = pesu_pkg::RST_UPRIGHT_ENERGY;
        gain_regs[pesu_pkg::CFG_POSITION_GAIN]  = pesu_pkg::RST_POSITION_GAIN;
        gain_regs[pesu_pkg::CFG_VELOCITY_GAIN]  = pesu_pkg::RST_VELOCITY_GAIN;
        gain_regs[pesu_pkg::CFG_BALANCE_LIMIT]  = pesu_pkg::RST_BALANCE_LIMIT;
        gain_regs[pesu_pkg::CFG_FRACTION_BASE]  = pesu_pkg::RST_FRACTION_BASE;
    endtask

    // cosine over the full turn by folding into the first quarter, q30 series
    task automatic build_tables();
        longint unsigned n, r, a, a2, t, x;
        longint unsigned den[6];
        longint unsigned z, z2, term, sum;
        bit neg;
        den = '{132, 90, 56, 30, 12, 2};
        n = 64'd1 << TRIG_BITS;
        for (int k = 0; k < (1 << TRIG_BITS); k++) begin
            r = k;
            neg = 0;
            if (r > n / 2) r = n - r;
            if (r > n / 4) begin
                neg = 1;
                r = n / 2 - r;
            end
            a  = (r * TWOPI_Q30) >> TRIG_BITS;
            a2 = (a * a) >> 30;
            t  = ONE_Q30;
            for (int i = 0; i < 6; i++) begin
                x = ((a2 * t) >> 30) / den[i];
                t = (x >= ONE_Q30) ? 0 : ONE_Q30 - x;
            end
            t = (t + (64'd1 << 13)) >> 14;
            cos_tab[k] = neg ? -longint'(t) : longint'(t);
        end
        // ln(1+k/n) through the atanh series
        n = 64'd1 << LOG_BITS;
        for (int k = 0; k <= (1 << LOG_BITS); k++) begin
            z    = (longint'(k) << 30) / (2 * n + k);
            z2   = (z * z) >> 30;
            term = z;
            sum  = 0;
            for (int i = 0; i < 14; i++) begin
                sum  += term / (2 * i + 1);
                term = (term * z2) >> 30;
            end
            lnq30_tab[k] = 2 * sum;
        end
    endtask

    function automatic longint unsigned mag(longint signed v);
        return v < 0 ? -v : v;
    endfunction

    function automatic int sgn(longint signed v);
        return v < 0 ? -1 : (v > 0 ? 1 : 0);
    endfunction

    // |ln(y/2^16)| in q16, y in 1..65536
    function automatic longint unsigned wall_log_q16(longint unsigned y);
        longint unsigned e, idx, m;
        if (y >= 65536 || y == 0) return 0;
        e = 0;
        while (y < 65536 && e < 17) begin
            y = y << 1;
            e++;
        end
        idx = ((y - 65536) + (64'd1 << (15 - LOG_BITS))) >> (16 - LOG_BITS);
        m = e * LN2_Q30_C - lnq30_tab[idx];
        return (m + (64'd1 << 13)) >> 14;
    endfunction

    function automatic t_command swing_law(t_sample s);
        t_command        c;
        longint signed   x, v, w, cosv, energy, u, sp;
        longint unsigned ath, aw, idx, ke, pe, frac, thr, ax, lt, ratio, wall;
        x = s.pos;
        v = s.vel;
        w = s.rate;
        ath = mag(s.ang);
        aw  = mag(w);
        idx = ((ath * INV_2PI_Q32 * (64'd1 << TRIG_BITS)) + (64'd1 << 47)) >> 48;
        cosv = cos_tab[idx & ((1 << TRIG_BITS) - 1)];
        ke = (((aw * aw) >> 16) * HALF_INER) >> 16;
        pe = (MGL * mag(cosv)) >> 16;
        energy = longint'(ke) + (cosv < 0 ? -longint'(pe) : longint'(pe));
        frac = gain_regs[pesu_pkg::CFG_FRACTION_BASE] + (longint'(s.us) * 65536) / RAMP_DEN;
        thr  = (gain_regs[pesu_pkg::CFG_UPRIGHT_ENERGY] * frac) >> 16;
        c.pump = energy <= longint'(thr);
        if (c.pump) begin
            u  = -longint'(sgn(w) * sgn(cosv))
                 * longint'(gain_regs[pesu_pkg::CFG_SWING_GAIN]);
            ax = mag(x);
            lt = gain_regs[pesu_pkg::CFG_TRACK_HALF_LEN];
            // at or past the track end the ratio clamps just below one
            ratio = (lt == 0) ? 65535 : (ax << 16) / lt;
            if (ratio > 65535) ratio = 65535;
            wall = (gain_regs[pesu_pkg::CFG_WALL_GAIN] * wall_log_q16(65536 - ratio)) >> 16;
            u -= longint'(sgn(x)) * longint'(wall);
        end else begin
            sp = longint'(gain_regs[pesu_pkg::CFG_POSITION_GAIN]) * x
               + longint'(gain_regs[pesu_pkg::CFG_VELOCITY_GAIN]) * v;
            u = (-sp) >>> 8;
        end
        if (u > 64'sd2147483647) u = 64'sd2147483647;
        if (u < -64'sd2147483648) u = -64'sd2147483648;
        c.accel = u[31:0];
        c.bal   = ath <= gain_regs[pesu_pkg::CFG_BALANCE_LIMIT];
        return c;
    endfunction

    // ---------------------------------------------------------------
    // sample driver: pops pending samples, predicts on acceptance
    // ---------------------------------------------------------------
    t_sample  sample_q[$];
    t_command command_q[$];
    int       tx_gap = 0;
    int       rx_gap = 0;
    bit       hold_tx = 0;
    bit       quiet = 0;
    int       mismatches = 0;
    t_sample  next_s;
    t_sample  cur_s;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            // beat accepted at this edge: record its expected command
            if (i_valid) begin
                cur_s = '{i_cart_position, i_cart_velocity, i_pendulum_angle,
                          i_angular_rate, i_swing_elapsed_us};
                command_q.push_back(swing_law(cur_s));
            end
            if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                i_valid <= 1'b0;
            end else if (sample_q.size() > 0 && !hold_tx) begin
                next_s = sample_q.pop_front();
                i_cart_position    <= next_s.pos;
                i_cart_velocity    <= next_s.vel;
                i_pendulum_angle   <= next_s.ang;
                i_angular_rate     <= next_s.rate;
                i_swing_elapsed_us <= next_s.us;
                i_valid <= 1'b1;
                if (!quiet && $urandom_range(0, 7) == 0) tx_gap <= $urandom_range(1, 5);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // output stall in bursts
    always @(posedge i_clk) begin
        if (quiet || !i_rst_n) begin
            i_stall <= 1'b0;
            rx_gap <= 0;
        end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            i_stall <= 1'b1;
        end else if ($urandom_range(0, 7) == 0) begin
            rx_gap <= $urandom_range(0, 4);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // command monitor
    // ---------------------------------------------------------------
    t_command want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (command_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected command beat: accel %0d", o_drive_accel);
            end else begin
                want = command_q.pop_front();
                if (o_drive_accel !== want.accel || o_pumping !== want.pump
                        || o_can_balance !== want.bal) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: accel %0d/%0d pump %0b/%0b bal %0b/%0b (exp/got)",
                                 want.accel, o_drive_accel, want.pump, o_pumping,
                                 want.bal, o_can_balance);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------
    task automatic write_reg(pesu_pkg::t_cfg_idx idx, longint unsigned val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[31:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        gain_regs[idx] = val & ((64'd1 << reg_bits(idx)) - 1);
    endtask

    // restore the power-on gains so the realistic operating point is covered too
    task automatic load_cfg_defaults_on_dut();
        write_reg(pesu_pkg::CFG_SWING_GAIN, pesu_pkg::RST_SWING_GAIN);
        write_reg(pesu_pkg::CFG_WALL_GAIN, pesu_pkg::RST_WALL_GAIN);
        write_reg(pesu_pkg::CFG_TRACK_HALF_LEN, pesu_pkg::RST_TRACK_HALF_LEN);
        write_reg(pesu_pkg::CFG_UPRIGHT_ENERGY, pesu_pkg::RST_UPRIGHT_ENERGY);
        write_reg(pesu_pkg::CFG_POSITION_GAIN, pesu_pkg::RST_POSITION_GAIN);
        write_reg(pesu_pkg::CFG_VELOCITY_GAIN, pesu_pkg::RST_VELOCITY_GAIN);
        write_reg(pesu_pkg::CFG_BALANCE_LIMIT, pesu_pkg::RST_BALANCE_LIMIT);
        write_reg(pesu_pkg::CFG_FRACTION_BASE, pesu_pkg::RST_FRACTION_BASE);
    endtask

    task automatic wait_drained();
        while (sample_q.size() > 0 || i_valid || command_q.size() > 0) @(posedge i_clk);
        repeat (LATENCY + 6) @(posedge i_clk);
    endtask

    task automatic add(int p, int v, int a, int r, int u);
        t_sample s;
        s = '{p[23:0], v[23:0], a[18:0], r[23:0], u[24:0]};
        sample_q.push_back(s);
    endtask

    task automatic add_random();
        t_sample s;
        int lt;
        lt = int'(gain_regs[pesu_pkg::CFG_TRACK_HALF_LEN]);
        s.pos  = 24'($urandom);
        s.vel  = 24'($urandom);
        s.ang  = 19'($urandom);
        s.rate = 24'($urandom);
        s.us   = 25'($urandom);
        // mostly physical samples: cart on the track, moderate rates
        if ($urandom_range(0, 3) != 0) begin
            s.pos  = 24'(int'($urandom_range(0, 2 * lt + 2)) - lt - 1);
            s.vel  = 24'(int'($urandom_range(0, 200000)) - 100000);
            s.rate = 24'(int'($urandom_range(0, 1600000)) - 800000);
            s.us   = 25'($urandom_range(0, 30000000));
            if ($urandom_range(0, 3) == 0) s.ang = 19'(int'($urandom_range(0, 12000)) - 6000);
        end
        sample_q.push_back(s);
    endtask

    initial begin
        load_defaults();
        build_tables();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, both branches, zero cosine and rate, cart at center/ends
        add(0, 0, 0, 0, 0);
        add(0, 0, 0, 300000, 0);
        add(0, 0, 205887, 0, 0);
        add(10000, -5000, 205887, 200000, 1000);
        add(-10000, 5000, -205887, -200000, 1000);
        add(20000, 0, QUARTER_TURN, 400000, 0);
        add(-20000, 0, -QUARTER_TURN, -400000, 0);
        add(38400, 0, 180000, 100000, 0);
        add(-38400, 0, 180000, -100000, 0);
        add(8388607, 8388607, 262143, 8388607, 33554431);
        add(-8388608, -8388608, -262144, -8388608, 33554431);
        add(8388607, -8388608, 0, 0, 0);
        add(-8388608, 8388607, 5719, 0, 0);
        add(1000, 1000, 5720, 1, 0);
        add(-1, -1, -5719, -1, 33554431);
        add(0, 100, 205000, 500000, 15000000);
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++) begin
            for (int r = 0; r < 8; r++) begin
                longint unsigned val;
                case (ph)
                    0: val = -64'sd1;                 // all ones, masked per register
                    1: val = 0;                       // zero everywhere, zero track too
                    2: val = (r == pesu_pkg::CFG_TRACK_HALF_LEN) ? 256 : 64'($urandom);
                    default: val = 64'($urandom);
                endcase
                if (ph >= 3 && r == pesu_pkg::CFG_TRACK_HALF_LEN)
                    val = 64'($urandom_range(256, 80000));
                if (ph >= 3 && r == pesu_pkg::CFG_UPRIGHT_ENERGY && ph[0])
                    val = 64'($urandom_range(20000000, 50000000));
                write_reg(pesu_pkg::t_cfg_idx'(r), val);
            end
            if (ph == 6) load_cfg_defaults_on_dut();
            if (ph == PHASES - 1) quiet = 1;
            for (int i = 0; i < PER_PHASE; i++) begin
                add_random();
                // drain check: stop sending until all commands are out
                if (ph == 4 && i == PER_PHASE / 2) begin
                    while (sample_q.size() > 0) @(posedge i_clk);
                    hold_tx = 1;
                    while (i_valid || command_q.size() > 0) @(posedge i_clk);
                    hold_tx = 0;
                end
            end
            wait_drained();
        end

        if (mismatches == 0 && command_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
